/* rtl/tkv_pkg.sv */
package tkv_pkg;

    // Table geometry
    localparam int ENTRIES = 16;
    localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CNT_W   = $clog2(ENTRIES + 1);

    // Field widths
    localparam int TAG_W     = 4;
    localparam int DATA_W    = 64;
    localparam int MODE_W    = 2;
    localparam int CFG_IDX_W = 2;

    // Operation codes
    localparam logic [MODE_W-1:0] MODE_SEARCH = 2'd0;
    localparam logic [MODE_W-1:0] MODE_INSERT = 2'd1;
    localparam logic [MODE_W-1:0] MODE_DELETE = 2'd2;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_NIL_TAG    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_NUMBER_TAG = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_STRING_TAG = 2'd2;

    // One table entry as stored in memory
    typedef struct packed {
        logic              valid;
        logic [TAG_W-1:0]  key_type;
        logic [DATA_W-1:0] key_bits;
        logic [TAG_W-1:0]  value_type;
        logic [DATA_W-1:0] value_bits;
    } entry_t;

    // Memory access request from the sequencer
    typedef struct packed {
        logic             rd_en;
        logic [IDX_W-1:0] rd_addr;
        logic             wr_en;
        logic [IDX_W-1:0] wr_addr;
        entry_t           wr_data;
    } mem_req_t;

    // Tag configuration
    typedef struct packed {
        logic [TAG_W-1:0] nil_tag;
        logic [TAG_W-1:0] number_tag;
        logic [TAG_W-1:0] string_tag;
    } cfg_t;

endpackage

/* rtl/tagged_key_value_store.sv */
// Associative table of ENTRIES tagged key/value entries held in one
// synchronous memory. An item is taken when start is high and busy is low;
// its result appears for exactly one cycle with done high and must be taken
// then, since the receiver cannot stall the block. Every item scans all
// entries through the single memory read port, one entry per cycle, and
// then writes back at most once; done rises in the same cycle that busy
// drops. After reset a clearing pass marks every entry free while busy is
// high. Configuration writes are taken any time but are meant to come only
// while the block is idle.
module tagged_key_value_store (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [tkv_pkg::MODE_W-1:0]    mode,
    input  logic [tkv_pkg::TAG_W-1:0]     key_type,
    input  logic [tkv_pkg::DATA_W-1:0]    key_bits,
    input  logic [tkv_pkg::TAG_W-1:0]     value_type,
    input  logic [tkv_pkg::DATA_W-1:0]    value_bits,
    input  logic                          cfg_we,
    input  logic [tkv_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [tkv_pkg::TAG_W-1:0]     cfg_data,
    output logic                          done,
    output logic                          hit,
    output logic                          table_full,
    output logic [tkv_pkg::TAG_W-1:0]     result_type,
    output logic [tkv_pkg::DATA_W-1:0]    result_bits
);
    import tkv_pkg::*;

    localparam logic [TAG_W-1:0] NIL_RESET    = 4'd0;
    localparam logic [TAG_W-1:0] NUMBER_RESET = 4'd3;
    localparam logic [TAG_W-1:0] STRING_RESET = 4'd4;

    cfg_t     cfg_reg;
    mem_req_t mem_req;
    entry_t   rd_data;

    // Tag configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.nil_tag    <= NIL_RESET;
            cfg_reg.number_tag <= NUMBER_RESET;
            cfg_reg.string_tag <= STRING_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_NIL_TAG:    cfg_reg.nil_tag    <= cfg_data;
                CFG_NUMBER_TAG: cfg_reg.number_tag <= cfg_data;
                CFG_STRING_TAG: cfg_reg.string_tag <= cfg_data;
                default:        cfg_reg            <= cfg_reg;
            endcase
        end
    end

    tkv_ctrl u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg_reg),
        .start       (start),
        .busy        (busy),
        .mode        (mode),
        .key_type    (key_type),
        .key_bits    (key_bits),
        .value_type  (value_type),
        .value_bits  (value_bits),
        .mem_req     (mem_req),
        .rd_data     (rd_data),
        .done        (done),
        .hit         (hit),
        .table_full  (table_full),
        .result_type (result_type),
        .result_bits (result_bits)
    );

    tkv_store u_store (
        .clk     (clk),
        .req     (mem_req),
        .rd_data (rd_data)
    );

endmodule

/* rtl/tkv_store.sv */
module tkv_store (
    input  logic              clk,
    input  tkv_pkg::mem_req_t req,
    output tkv_pkg::entry_t   rd_data
);
    import tkv_pkg::*;

    entry_t mem [ENTRIES];
    entry_t rd_data_reg;

    // Single-port-style write, registered read
    always_ff @(posedge clk)
    begin
        if (req.wr_en)
        begin
            mem[req.wr_addr] <= req.wr_data;
        end
        if (req.rd_en)
        begin
            rd_data_reg <= mem[req.rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

/* rtl/tkv_ctrl.sv */
module tkv_ctrl (
    input  logic                         clk,
    input  logic                         rst_n,
    input  tkv_pkg::cfg_t                cfg,
    input  logic                         start,
    output logic                         busy,
    input  logic [tkv_pkg::MODE_W-1:0]   mode,
    input  logic [tkv_pkg::TAG_W-1:0]    key_type,
    input  logic [tkv_pkg::DATA_W-1:0]   key_bits,
    input  logic [tkv_pkg::TAG_W-1:0]    value_type,
    input  logic [tkv_pkg::DATA_W-1:0]   value_bits,
    output tkv_pkg::mem_req_t            mem_req,
    input  tkv_pkg::entry_t              rd_data,
    output logic                         done,
    output logic                         hit,
    output logic                         table_full,
    output logic [tkv_pkg::TAG_W-1:0]    result_type,
    output logic [tkv_pkg::DATA_W-1:0]   result_bits
);
    import tkv_pkg::*;

    localparam logic [1:0] ST_CLEAR = 2'd0;
    localparam logic [1:0] ST_IDLE  = 2'd1;
    localparam logic [1:0] ST_SCAN  = 2'd2;

    localparam logic [CNT_W-1:0] CNT_END  = CNT_W'(ENTRIES);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(ENTRIES - 1);

    logic [1:0]        state_reg, state_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic              rd_vld_reg, rd_vld_next;
    logic [IDX_W-1:0]  rd_idx_reg, rd_idx_next;

    logic [MODE_W-1:0] op_mode_reg, op_mode_next;
    logic [TAG_W-1:0]  op_ktype_reg, op_ktype_next;
    logic [DATA_W-1:0] op_kbits_reg, op_kbits_next;
    logic [TAG_W-1:0]  op_vtype_reg, op_vtype_next;
    logic [DATA_W-1:0] op_vbits_reg, op_vbits_next;

    logic              found_reg, found_next;
    logic [IDX_W-1:0]  found_idx_reg, found_idx_next;
    logic [TAG_W-1:0]  fval_type_reg, fval_type_next;
    logic [DATA_W-1:0] fval_bits_reg, fval_bits_next;
    logic              free_reg, free_next;
    logic [IDX_W-1:0]  free_idx_reg, free_idx_next;

    logic              done_reg, done_next;
    logic              hit_reg, hit_next;
    logic              full_reg, full_next;
    logic [TAG_W-1:0]  rtype_reg, rtype_next;
    logic [DATA_W-1:0] rbits_reg, rbits_next;

    logic              match;
    logic              free_here;
    logic              scan_end;
    entry_t            new_entry;

    // Compare of the entry read last cycle
    assign match = rd_vld_reg && rd_data.valid
                   && (rd_data.key_type == op_ktype_reg)
                   && (rd_data.key_bits == op_kbits_reg);
    assign free_here = rd_vld_reg && !rd_data.valid;
    assign scan_end  = (state_reg == ST_SCAN) && (cnt_reg == CNT_END) && !rd_vld_reg;

    always_comb
    begin
        new_entry.valid      = 1'b1;
        new_entry.key_type   = op_ktype_reg;
        new_entry.key_bits   = op_kbits_reg;
        new_entry.value_type = op_vtype_reg;
        new_entry.value_bits = op_vbits_reg;
    end

    // Sequencer: clearing pass, scan, write-back
    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        rd_vld_next    = 1'b0;
        rd_idx_next    = cnt_reg[IDX_W-1:0];
        op_mode_next   = op_mode_reg;
        op_ktype_next  = op_ktype_reg;
        op_kbits_next  = op_kbits_reg;
        op_vtype_next  = op_vtype_reg;
        op_vbits_next  = op_vbits_reg;
        found_next     = found_reg;
        found_idx_next = found_idx_reg;
        fval_type_next = fval_type_reg;
        fval_bits_next = fval_bits_reg;
        free_next      = free_reg;
        free_idx_next  = free_idx_reg;
        done_next      = 1'b0;
        hit_next       = hit_reg;
        full_next      = full_reg;
        rtype_next     = rtype_reg;
        rbits_next     = rbits_reg;
        mem_req        = '0;

        case (state_reg)
            ST_CLEAR:
            begin
                mem_req.wr_en   = 1'b1;
                mem_req.wr_addr = cnt_reg[IDX_W-1:0];
                if (cnt_reg == CNT_LAST)
                begin
                    cnt_next   = '0;
                    state_next = ST_IDLE;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end

            ST_IDLE:
            begin
                if (start)
                begin
                    op_mode_next  = mode;
                    op_kbits_next = key_bits;
                    op_vtype_next = value_type;
                    op_vbits_next = value_bits;
                    // search coerces every non-string key to the number tag
                    if ((mode == MODE_SEARCH) && (key_type != cfg.string_tag))
                    begin
                        op_ktype_next = cfg.number_tag;
                    end
                    else
                    begin
                        op_ktype_next = key_type;
                    end
                    found_next = 1'b0;
                    free_next  = 1'b0;
                    cnt_next   = '0;
                    state_next = ST_SCAN;
                end
            end

            ST_SCAN:
            begin
                // issue one read per cycle
                if (cnt_reg != CNT_END)
                begin
                    mem_req.rd_en   = 1'b1;
                    mem_req.rd_addr = cnt_reg[IDX_W-1:0];
                    rd_vld_next     = 1'b1;
                    cnt_next        = cnt_reg + 1'b1;
                end

                // keep the lowest match and lowest free slot
                if (match && !found_reg)
                begin
                    found_next     = 1'b1;
                    found_idx_next = rd_idx_reg;
                    fval_type_next = rd_data.value_type;
                    fval_bits_next = rd_data.value_bits;
                end
                if (free_here && !free_reg)
                begin
                    free_next     = 1'b1;
                    free_idx_next = rd_idx_reg;
                end

                // write back and post the result
                if (scan_end)
                begin
                    done_next  = 1'b1;
                    hit_next   = 1'b0;
                    full_next  = 1'b0;
                    rtype_next = '0;
                    rbits_next = '0;
                    state_next = ST_IDLE;
                    case (op_mode_reg)
                        MODE_SEARCH:
                        begin
                            hit_next = found_reg;
                            if (found_reg)
                            begin
                                rtype_next = fval_type_reg;
                                rbits_next = fval_bits_reg;
                            end
                            else
                            begin
                                rtype_next = cfg.nil_tag;
                            end
                        end
                        MODE_INSERT:
                        begin
                            if (found_reg)
                            begin
                                hit_next        = 1'b1;
                                mem_req.wr_en   = 1'b1;
                                mem_req.wr_addr = found_idx_reg;
                                mem_req.wr_data = new_entry;
                            end
                            else if (free_reg)
                            begin
                                mem_req.wr_en   = 1'b1;
                                mem_req.wr_addr = free_idx_reg;
                                mem_req.wr_data = new_entry;
                            end
                            else
                            begin
                                full_next = 1'b1;
                            end
                        end
                        MODE_DELETE:
                        begin
                            if (found_reg)
                            begin
                                hit_next        = 1'b1;
                                mem_req.wr_en   = 1'b1;
                                mem_req.wr_addr = found_idx_reg;
                            end
                        end
                        default:
                        begin
                            hit_next = 1'b0;
                        end
                    endcase
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_CLEAR;
            cnt_reg    <= '0;
            rd_vld_reg <= 1'b0;
            found_reg  <= 1'b0;
            free_reg   <= 1'b0;
            done_reg   <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            cnt_reg    <= cnt_next;
            rd_vld_reg <= rd_vld_next;
            found_reg  <= found_next;
            free_reg   <= free_next;
            done_reg   <= done_next;
        end
    end

    // Payload
    always_ff @(posedge clk)
    begin
        rd_idx_reg    <= rd_idx_next;
        op_mode_reg   <= op_mode_next;
        op_ktype_reg  <= op_ktype_next;
        op_kbits_reg  <= op_kbits_next;
        op_vtype_reg  <= op_vtype_next;
        op_vbits_reg  <= op_vbits_next;
        found_idx_reg <= found_idx_next;
        fval_type_reg <= fval_type_next;
        fval_bits_reg <= fval_bits_next;
        free_idx_reg  <= free_idx_next;
        hit_reg       <= hit_next;
        full_reg      <= full_next;
        rtype_reg     <= rtype_next;
        rbits_reg     <= rbits_next;
    end

    assign busy        = (state_reg != ST_IDLE);
    assign done        = done_reg;
    assign hit         = hit_reg;
    assign table_full  = full_reg;
    assign result_type = rtype_reg;
    assign result_bits = rbits_reg;

endmodule
